FILE: rtl/sdeq_pkg.sv
// ----------------------------------------------------------------------------
// sdeq_pkg: shared types and constants of the sorted double-ended queue
// Opcodes, status codes, cell commands and the structs that travel between
// the top level and the cells of the sorted chain.
// ----------------------------------------------------------------------------
package sdeq_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);

    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_POP_MIN = 2'd1,
        OP_POP_MAX = 2'd2,
        OP_LIST    = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LIST
    } t_state;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT_LEFT,
        CELL_ROTATE
    } t_cell_op;

    // broadcast command to every cell
    typedef struct packed {
        t_cell_op                  op;
        logic signed [DATA_W-1:0]  value;
    } t_cell_ctl;

    // where a cell sits relative to the fill count
    typedef struct packed {
        logic occ;      // holds a stored value
        logic is_tail;  // first free slot
        logic is_last;  // last stored value
    } t_cell_pos;

    // what a cell hands to its right neighbor
    typedef struct packed {
        logic                      shift;
        logic signed [DATA_W-1:0]  val;
    } t_link;

endpackage

FILE: rtl/sorted_double_ended_queue_top.sv
// ----------------------------------------------------------------------------
// sorted_double_ended_queue_top: bounded sorted double-ended priority queue
// Keeps up to CAPACITY signed 32-bit values in ascending order in a chain of
// cells and serves insert, remove-smallest, remove-largest and list.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive i_opcode / i_value and raise start. The
//   transaction is taken at the rising edge where start is high and busy is
//   low. Opcodes: insert, remove smallest, remove largest, list all.
//   Result channel: each result sits on o_value_out / o_status / o_last for
//   exactly one cycle with o_strobe high; the receiver cannot stall, so
//   results must be captured in that cycle.
// Operation:
//   The command is registered on acceptance and executed by all cells in
//   parallel in the next cycle, and its result is registered onto the
//   ports. Insert and both removes give one result each; the block takes
//   no new command while it executes one.
//   List walks the stored values by rotating the chain one slot a cycle,
//   and yields one result per cycle, smallest first, o_last on the final
//   one. After a full rotation the chain is back in its original order.
// Reset:
//   i_rst_n (synchronous, active low) empties the queue and clears the
//   control state; cell contents are not cleared, only the fill count.
// ----------------------------------------------------------------------------
module sorted_double_ended_queue_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    input  logic [1:0]                         i_opcode,
    input  logic signed [sdeq_pkg::DATA_W-1:0] i_value,
    output logic                               busy,
    output logic                               o_strobe,
    output logic signed [sdeq_pkg::DATA_W-1:0] o_value_out,
    output logic [1:0]                         o_status,
    output logic                               o_last
);

    localparam int CAP = sdeq_pkg::CAPACITY;

    // control state
    sdeq_pkg::t_state                   r_state, n_state;
    logic [sdeq_pkg::CNT_W-1:0]         r_count, n_count;
    logic [sdeq_pkg::CNT_W-1:0]         r_remain, n_remain;

    // latched command
    sdeq_pkg::t_opcode                  r_op;
    logic signed [sdeq_pkg::DATA_W-1:0] r_value;

    // result registers
    logic                               r_strobe, n_strobe;
    logic signed [sdeq_pkg::DATA_W-1:0] r_value_out, n_value_out;
    sdeq_pkg::t_status                  r_status, n_status;
    logic                               r_last, n_last;

    // chain wiring
    sdeq_pkg::t_cell_ctl                w_ctl;
    sdeq_pkg::t_link                    w_link [CAP];
    logic [sdeq_pkg::CNT_W-1:0]         w_count_m1;
    logic [sdeq_pkg::IDX_W-1:0]         w_top_idx;
    logic                               w_accept;
    logic                               w_empty;
    logic                               w_full;

    assign w_accept   = start && !busy;
    assign w_empty    = (r_count == '0);
    assign w_full     = (r_count == sdeq_pkg::CNT_W'(CAP));
    assign w_count_m1 = r_count - 1'b1;
    assign w_top_idx  = w_count_m1[sdeq_pkg::IDX_W-1:0];

    // ------------------------------------------------------------------
    // Cell chain: each cell sees its left neighbor's link and its right
    // neighbor's value; cell zero's value is the rotation wrap-around.
    // ------------------------------------------------------------------
    for (genvar gi = 0; gi < CAP; gi++) begin : g_cell
        sdeq_pkg::t_cell_pos                w_pos;
        sdeq_pkg::t_link                    w_left;
        logic signed [sdeq_pkg::DATA_W-1:0] w_right;

        assign w_pos.occ     = (sdeq_pkg::CNT_W'(gi) < r_count);
        assign w_pos.is_tail = (sdeq_pkg::CNT_W'(gi) == r_count);
        assign w_pos.is_last = (sdeq_pkg::CNT_W'(gi) == w_count_m1);

        if (gi == 0) begin : g_head
            assign w_left = '0;
        end else begin : g_body
            assign w_left = w_link[gi-1];
        end

        if (gi == CAP - 1) begin : g_end
            assign w_right = '0;
        end else begin : g_mid
            assign w_right = w_link[gi+1].val;
        end

        sdeq_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_pos       (w_pos),
            .i_left      (w_left),
            .i_right_val (w_right),
            .i_wrap_val  (w_link[0].val),
            .o_link      (w_link[gi])
        );
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sdeq_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = sdeq_pkg::S_EXEC;
                end
            end
            sdeq_pkg::S_EXEC: begin
                // a list of two or more keeps walking
                if ((r_op == sdeq_pkg::OP_LIST) && (r_count > sdeq_pkg::CNT_W'(1))) begin
                    n_state = sdeq_pkg::S_LIST;
                end else begin
                    n_state = sdeq_pkg::S_IDLE;
                end
            end
            sdeq_pkg::S_LIST: begin
                if (r_remain == sdeq_pkg::CNT_W'(1)) begin
                    n_state = sdeq_pkg::S_IDLE;
                end
            end
            default: n_state = sdeq_pkg::S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Outputs: cell command, fill count and result
    // ------------------------------------------------------------------
    always_comb begin
        w_ctl.op    = sdeq_pkg::CELL_HOLD;
        w_ctl.value = r_value;
        n_count     = r_count;
        n_remain    = r_remain;
        n_strobe    = 1'b0;
        n_value_out = '0;
        n_status    = sdeq_pkg::ST_OK;
        n_last      = 1'b1;

        unique case (r_state)
            sdeq_pkg::S_IDLE: begin
                // hold
            end
            sdeq_pkg::S_EXEC: begin
                n_strobe = 1'b1;
                unique case (r_op)
                    sdeq_pkg::OP_INSERT: begin
                        if (w_full) begin
                            n_status = sdeq_pkg::ST_FULL;
                        end else begin
                            w_ctl.op = sdeq_pkg::CELL_INSERT;
                            n_count  = r_count + 1'b1;
                        end
                    end
                    sdeq_pkg::OP_POP_MIN: begin
                        if (w_empty) begin
                            n_status = sdeq_pkg::ST_EMPTY;
                        end else begin
                            w_ctl.op    = sdeq_pkg::CELL_SHIFT_LEFT;
                            n_value_out = w_link[0].val;
                            n_count     = w_count_m1;
                        end
                    end
                    sdeq_pkg::OP_POP_MAX: begin
                        if (w_empty) begin
                            n_status = sdeq_pkg::ST_EMPTY;
                        end else begin
                            // drop the top entry, cells stay put
                            n_value_out = w_link[w_top_idx].val;
                            n_count     = w_count_m1;
                        end
                    end
                    sdeq_pkg::OP_LIST: begin
                        if (w_empty) begin
                            n_status = sdeq_pkg::ST_EMPTY;
                        end else begin
                            w_ctl.op    = sdeq_pkg::CELL_ROTATE;
                            n_value_out = w_link[0].val;
                            n_last      = (r_count == sdeq_pkg::CNT_W'(1));
                            n_remain    = w_count_m1;
                        end
                    end
                    default: n_status = sdeq_pkg::ST_OK;
                endcase
            end
            sdeq_pkg::S_LIST: begin
                // advance the rotation, emit the new head
                w_ctl.op    = sdeq_pkg::CELL_ROTATE;
                n_strobe    = 1'b1;
                n_value_out = w_link[0].val;
                n_last      = (r_remain == sdeq_pkg::CNT_W'(1));
                n_remain    = r_remain - 1'b1;
            end
            default: n_strobe = 1'b0;
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sdeq_pkg::S_IDLE;
            r_count  <= '0;
            r_remain <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_remain <= n_remain;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op    <= sdeq_pkg::t_opcode'(i_opcode);
            r_value <= i_value;
        end
        r_value_out <= n_value_out;
        r_status    <= n_status;
        r_last      <= n_last;
    end

    assign busy        = (r_state != sdeq_pkg::S_IDLE);
    assign o_strobe    = r_strobe;
    assign o_value_out = r_value_out;
    assign o_status    = r_status;
    assign o_last      = r_last;

endmodule

FILE: rtl/sdeq_cell.sv
// ----------------------------------------------------------------------------
// sdeq_cell: one slot of the sorted chain
// Holds one value; on insert, compares against the broadcast value and
// shifts right; on pop-min shifts left; on list rotates left.
// ----------------------------------------------------------------------------
module sdeq_cell (
    input  logic                               i_clk,
    input  sdeq_pkg::t_cell_ctl                i_ctl,
    input  sdeq_pkg::t_cell_pos                i_pos,
    input  sdeq_pkg::t_link                    i_left,
    input  logic signed [sdeq_pkg::DATA_W-1:0] i_right_val,
    input  logic signed [sdeq_pkg::DATA_W-1:0] i_wrap_val,
    output sdeq_pkg::t_link                    o_link
);

    logic signed [sdeq_pkg::DATA_W-1:0] r_val;
    logic signed [sdeq_pkg::DATA_W-1:0] n_val;
    logic                               w_shift;

    // insert goes after equal values, so shift only on strictly less
    assign w_shift = i_pos.occ && (i_ctl.value < r_val);

    always_comb begin
        n_val = r_val;
        unique case (i_ctl.op)
            sdeq_pkg::CELL_HOLD: begin
                n_val = r_val;
            end
            sdeq_pkg::CELL_INSERT: begin
                if (w_shift || i_pos.is_tail) begin
                    n_val = i_left.shift ? i_left.val : i_ctl.value;
                end
            end
            sdeq_pkg::CELL_SHIFT_LEFT: begin
                if (i_pos.occ) begin
                    n_val = i_right_val;
                end
            end
            sdeq_pkg::CELL_ROTATE: begin
                if (i_pos.occ) begin
                    n_val = i_pos.is_last ? i_wrap_val : i_right_val;
                end
            end
            default: n_val = r_val;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_link.shift = w_shift;
    assign o_link.val   = r_val;

endmodule

FILE: rtl/sdeq_checker.sv
// ----------------------------------------------------------------------------
// sdeq_checker: port-level checks of the sorted double-ended queue
// Watches the command and result channels over time; bound to the top level.
// ----------------------------------------------------------------------------
module sdeq_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               start,
    input logic                               busy,
    input logic                               o_strobe,
    input logic signed [sdeq_pkg::DATA_W-1:0] o_value_out,
    input logic [1:0]                         o_status,
    input logic                               o_last
);

    // an accepted transaction holds the block busy and shows no result yet
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_strobe))
        else $error("accepted transaction did not raise busy");

    // a result without last is followed at once by the next result
    a_list_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |=> o_strobe)
        else $error("result burst broke before last");

    // the final result of a transaction frees the command channel
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |-> !busy)
        else $error("busy still high on final result");

    // empty and full answers carry a zero value and end the transaction
    a_error_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status != sdeq_pkg::ST_OK))
            |-> ((o_value_out == '0) && o_last
                 && ((o_status == sdeq_pkg::ST_EMPTY) || (o_status == sdeq_pkg::ST_FULL))))
        else $error("malformed empty or full result");

endmodule

bind sorted_double_ended_queue_top sdeq_checker u_sdeq_checker (.*);

FILE: tb/tb_sorted_double_ended_queue_top.sv
// ----------------------------------------------------------------------------
// tb_sorted_double_ended_queue_top: self-checking bench for the sorted queue
// Drives insert, remove-smallest, remove-largest and list transactions with
// bursty pacing, predicts every result from a behavioral copy of the sorted
// contents and checks each strobed result against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_sorted_double_ended_queue_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 100000;
    localparam int SETTLE_TICKS = 8;

    // one expected result of the block
    typedef struct {
        logic signed [sdeq_pkg::DATA_W-1:0] value;
        sdeq_pkg::t_status                  status;
        logic                               last;
    } t_queue_answer;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               start = 1'b0;
    logic [1:0]                         i_opcode = '0;
    logic signed [sdeq_pkg::DATA_W-1:0] i_value = '0;
    logic                               busy;
    logic                               o_strobe;
    logic signed [sdeq_pkg::DATA_W-1:0] o_value_out;
    logic [1:0]                         o_status;
    logic                               o_last;

    // behavioral copy of the stored values, kept in ascending order
    logic signed [sdeq_pkg::DATA_W-1:0] sorted_copy[$];
    // results still owed by the block, oldest first
    t_queue_answer                      owed_answers[$];

    int  fail_count = 0;
    int  cycle_count = 0;
    bit  pacing_on = 1'b1;
    int  burst_left = 1;

    sorted_double_ended_queue_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_opcode    (i_opcode),
        .i_value     (i_value),
        .busy        (busy),
        .o_strobe    (o_strobe),
        .o_value_out (o_value_out),
        .o_status    (o_status),
        .o_last      (o_last)
    );

    always #5 i_clk = ~i_clk;

    // Watchdog: end the run if the stimulus or the drain hangs.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Prediction: apply one accepted transaction to the sorted copy and queue
    // the results it must produce.
    // ------------------------------------------------------------------------
    function automatic void owe(logic signed [sdeq_pkg::DATA_W-1:0] v,
                                sdeq_pkg::t_status st, logic lst);
        t_queue_answer a;
        a.value  = v;
        a.status = st;
        a.last   = lst;
        owed_answers.push_back(a);
    endfunction

    function automatic void apply_to_sorted_copy(sdeq_pkg::t_opcode op,
                                                 logic signed [sdeq_pkg::DATA_W-1:0] v);
        int pos;
        pos = 0;
        case (op)
            sdeq_pkg::OP_INSERT: begin
                if (sorted_copy.size() >= sdeq_pkg::CAPACITY) begin
                    // drop the value, report full
                    owe('0, sdeq_pkg::ST_FULL, 1'b1);
                end else begin
                    // place after any equal values
                    while (pos < sorted_copy.size() && !(v < sorted_copy[pos]))
                        pos++;
                    sorted_copy.insert(pos, v);
                    owe('0, sdeq_pkg::ST_OK, 1'b1);
                end
            end
            sdeq_pkg::OP_POP_MIN: begin
                if (sorted_copy.size() == 0)
                    owe('0, sdeq_pkg::ST_EMPTY, 1'b1);
                else
                    owe(sorted_copy.pop_front(), sdeq_pkg::ST_OK, 1'b1);
            end
            sdeq_pkg::OP_POP_MAX: begin
                if (sorted_copy.size() == 0)
                    owe('0, sdeq_pkg::ST_EMPTY, 1'b1);
                else
                    owe(sorted_copy.pop_back(), sdeq_pkg::ST_OK, 1'b1);
            end
            default: begin
                // list all: contents stay as they are
                if (sorted_copy.size() == 0) begin
                    owe('0, sdeq_pkg::ST_EMPTY, 1'b1);
                end else begin
                    foreach (sorted_copy[i])
                        owe(sorted_copy[i], sdeq_pkg::ST_OK, (i == sorted_copy.size() - 1));
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Result checking: sample at the edge that ends the strobe cycle.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_queue_answer want;
        if (i_rst_n && o_strobe === 1'b1) begin
            if (owed_answers.size() == 0) begin
                $display("%0t: unexpected result value=%0d status=%0d last=%0d",
                         $realtime, o_value_out, o_status, o_last);
                fail_count++;
            end else begin
                want = owed_answers.pop_front();
                if (o_value_out !== want.value) begin
                    $display("%0t: value_out expected %0d actual %0d",
                             $realtime, want.value, o_value_out);
                    fail_count++;
                end
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $realtime, want.status, o_status);
                    fail_count++;
                end
                if (o_last !== want.last) begin
                    $display("%0t: last expected %0d actual %0d",
                             $realtime, want.last, o_last);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------

    // Hold start high until the block takes the transaction, then predict.
    // Call at a rising edge; start stays high so a burst runs back to back.
    task automatic send_command(input sdeq_pkg::t_opcode op,
                                input logic signed [sdeq_pkg::DATA_W-1:0] v);
        start    <= 1'b1;
        i_opcode <= op;
        i_value  <= v;
        do
            @(posedge i_clk);
        while (busy !== 1'b0);
        apply_to_sorted_copy(op, v);
        // Bursts of random length, then a random gap. The gaps land on every
        // phase of a list walk as well as short commands.
        if (pacing_on) begin
            burst_left--;
            if (burst_left <= 0) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
                burst_left = $urandom_range(1, 12);
            end
        end
    endtask

    // Drop start and hold off until every owed result has come.
    task automatic wait_for_drain();
        start <= 1'b0;
        while (owed_answers.size() != 0)
            @(posedge i_clk);
    endtask

    // Small values often enough that duplicates are common, plus extremes
    // and fully random words.
    function automatic logic signed [sdeq_pkg::DATA_W-1:0] pick_value();
        logic signed [sdeq_pkg::DATA_W-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = {1'b0, {(sdeq_pkg::DATA_W-1){1'b1}}};
            1:       v = {1'b1, {(sdeq_pkg::DATA_W-1){1'b0}}};
            2, 3, 4: v = $signed($urandom_range(0, 16)) - 8;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Removing or listing with nothing stored answers empty.
    task automatic test_empty_queue();
        send_command(sdeq_pkg::OP_POP_MIN, $urandom);
        send_command(sdeq_pkg::OP_POP_MAX, $urandom);
        send_command(sdeq_pkg::OP_LIST, $urandom);
    endtask

    // Extremes of the value range, a duplicate, a list, then both removes.
    task automatic test_value_extremes();
        send_command(sdeq_pkg::OP_INSERT, {1'b0, {(sdeq_pkg::DATA_W-1){1'b1}}});
        send_command(sdeq_pkg::OP_INSERT, {1'b1, {(sdeq_pkg::DATA_W-1){1'b0}}});
        send_command(sdeq_pkg::OP_INSERT, '0);
        send_command(sdeq_pkg::OP_INSERT, '1);
        send_command(sdeq_pkg::OP_INSERT, '0);
        send_command(sdeq_pkg::OP_LIST, $urandom);
        send_command(sdeq_pkg::OP_POP_MIN, $urandom);
        send_command(sdeq_pkg::OP_POP_MAX, $urandom);
    endtask

    // Fill to capacity, insert once more to see it dropped, list a full queue.
    task automatic test_full_queue();
        while (sorted_copy.size() < sdeq_pkg::CAPACITY)
            send_command(sdeq_pkg::OP_INSERT, pick_value());
        send_command(sdeq_pkg::OP_INSERT, pick_value());
        send_command(sdeq_pkg::OP_LIST, $urandom);
    endtask

    // Random traffic; weights are percentages for insert, pop-min and pop-max,
    // the rest go to list.
    task automatic test_random_traffic(input int count, input int w_ins,
                                       input int w_min, input int w_max);
        int                pick;
        sdeq_pkg::t_opcode op;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < w_ins)
                op = sdeq_pkg::OP_INSERT;
            else if (pick < w_ins + w_min)
                op = sdeq_pkg::OP_POP_MIN;
            else if (pick < w_ins + w_min + w_max)
                op = sdeq_pkg::OP_POP_MAX;
            else
                op = sdeq_pkg::OP_LIST;
            send_command(op, pick_value());
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        // Hold reset, then release it on an edge.
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part back to back, no idling.
        pacing_on = 1'b0;
        test_empty_queue();
        test_value_extremes();
        test_full_queue();
        wait_for_drain();

        pacing_on  = 1'b1;
        burst_left = $urandom_range(1, 12);
        @(posedge i_clk);
        // Drain-heavy from full, down through empty.
        test_random_traffic(60, 15, 35, 35);
        // Mixed.
        test_random_traffic(60, 40, 20, 20);
        wait_for_drain();
        @(posedge i_clk);

        // Fill-heavy with no idling, to run into full repeatedly.
        pacing_on = 1'b0;
        test_random_traffic(60, 70, 10, 10);
        pacing_on = 1'b1;
        // List-heavy over a well-stocked queue.
        test_random_traffic(40, 40, 10, 10);
        // Fill then drain.
        test_random_traffic(40, 75, 10, 10);
        test_random_traffic(40, 10, 40, 40);

        // Drain, then let any trailing work settle.
        wait_for_drain();
        repeat (SETTLE_TICKS) @(posedge i_clk);

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
